@@ rtl/lcdre_pkg.sv @@
// ============================================================================
// lcdre_pkg
// Shared types and constants for the color-table change detector with
// per-row run segments.
// ============================================================================
package lcdre_pkg;

    // Fixed field widths
    localparam int FIELD_W = 12;
    localparam int CFG_W   = 13;
    localparam int CHAN_W  = 8;
    localparam int ENTRY_W = 9;
    localparam int CODE_W  = 8;

    // Input word kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_TABLE = 1'b1;

    // Configuration register indexes
    localparam int            CFG_IDX_W        = 2;
    localparam logic [1:0]    CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0]    CFG_FRAME_HEIGHT = 2'd1;

    // Result queue geometry (power of two)
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // One result word
    typedef struct packed {
        logic               changed;
        logic               segment_valid;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] first_col;
        logic [FIELD_W-1:0] final_col;
        logic               last;
    } t_result;

    // Push request from the compare stage into the result queue
    typedef struct packed {
        logic [1:0] num;
        t_result    word0;
        t_result    word1;
    } t_push;

endpackage

@@ rtl/lut_color_diff_run_extractor_core.sv @@
// ============================================================================
// lut_color_diff_run_extractor_core
// Color-table change detector that reports runs of changed pixels per row.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per handshake:
//   either a table write (i_action = 1, i_entry_index, i_entry_code) or a
//   pixel pair in raster order (i_action = 0, BGR of both frames).
//   Output channel (o_out_valid / i_out_ready) gives one or two words per
//   pixel; o_last marks the final word of a pixel. Table writes give none.
//   Flow: a pixel is looked up in the table on the edge that accepts it;
//   the registered codes are then compared and the results written to the
//   result queue, from which the output channel takes them.
//   Throughput: one input word per cycle while o_in_ready is high; the color
//   table is two copies of a one-port-read RAM so both pixels are looked up
//   in the same cycle. Output drains one word per cycle while i_out_ready is
//   high; pixels that close two runs add a word to the 8-word result queue.
//   Receiver stall: words wait in the queue; o_in_ready drops once the queue
//   could not take the results of the pixels in flight.
//   Reset: counters and run state clear; frame width and height return to
//   640 x 480. The color table is not cleared and must be loaded before use.
//   Configuration (i_cfg_we) must be written while idle; it is not enforced.
// ============================================================================
module lut_color_diff_run_extractor_core #(
    parameter int MAX_COLUMNS        = 4096,
    parameter int MAX_ROWS           = 4096,
    parameter int CHANNEL_INDEX_BITS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lcdre_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lcdre_pkg::CFG_W-1:0]       i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [lcdre_pkg::CHAN_W-1:0]      i_blue_a,
    input  logic [lcdre_pkg::CHAN_W-1:0]      i_green_a,
    input  logic [lcdre_pkg::CHAN_W-1:0]      i_red_a,
    input  logic [lcdre_pkg::CHAN_W-1:0]      i_blue_b,
    input  logic [lcdre_pkg::CHAN_W-1:0]      i_green_b,
    input  logic [lcdre_pkg::CHAN_W-1:0]      i_red_b,
    input  logic [lcdre_pkg::ENTRY_W-1:0]     i_entry_index,
    input  logic [lcdre_pkg::CODE_W-1:0]      i_entry_code,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_changed,
    output logic                              o_segment_valid,
    output logic [lcdre_pkg::FIELD_W-1:0]     o_segment_row,
    output logic [lcdre_pkg::FIELD_W-1:0]     o_segment_first,
    output logic [lcdre_pkg::FIELD_W-1:0]     o_segment_final,
    output logic                              o_last
);
    import lcdre_pkg::*;

    localparam int IDX_W   = 3 * CHANNEL_INDEX_BITS;
    localparam int DEPTH   = 1 << IDX_W;
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WLIM_W  = $clog2(MAX_COLUMNS + 1);
    localparam int HLIM_W  = $clog2(MAX_ROWS + 1) > 0 ? $clog2(MAX_ROWS + 1) : 1;

    // Clamp a dimension register to 1..maxv
    function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v,
                                              input logic [31:0] maxv);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return 32'd1;
        end else if (v32 > maxv) begin
            return maxv;
        end else begin
            return v32;
        end
    endfunction

    logic                  in_acc;
    logic                  tbl_we;
    logic                  pix_re;
    logic [IDX_W-1:0]      idx_a, idx_b, idx_w;
    logic [CODE_W-1:0]     code_a, code_b;

    logic [WLIM_W-1:0]     r_width_lim;
    logic [HLIM_W-1:0]     r_height_lim;
    logic                  r_s1_valid;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic                  r_run_open, n_run_open;
    logic [COL_W-1:0]      r_run_start, n_run_start;
    logic [COL_W-1:0]      r_last_hit, n_last_hit;

    logic                  changed;
    logic                  gap;
    logic                  open1;
    logic [COL_W-1:0]      start1, hit1;
    logic                  end_row;
    logic                  seg_end;
    t_result               res_gap, res_end, res_plain;
    t_push                 push;
    logic [OQ_CNT_W-1:0]   oq_count;
    logic [OQ_CNT_W:0]     oq_need;
    t_result               out_word;

    // Input handshake: leave room for the results of the pixel in flight
    assign oq_need    = (OQ_CNT_W + 1)'(oq_count) +
                        (r_s1_valid ? (OQ_CNT_W + 1)'(2) : (OQ_CNT_W + 1)'(0));
    assign o_in_ready = (oq_need <= (OQ_CNT_W + 1)'(OQ_DEPTH - 2));
    assign in_acc     = i_in_valid && o_in_ready;
    assign tbl_we     = in_acc && (i_action == ACT_TABLE);
    assign pix_re     = in_acc && (i_action == ACT_PIXEL);

    // Quantize each pixel to a table index red|green|blue
    assign idx_a = {i_red_a[CHAN_W-1 -: CHANNEL_INDEX_BITS],
                    i_green_a[CHAN_W-1 -: CHANNEL_INDEX_BITS],
                    i_blue_a[CHAN_W-1 -: CHANNEL_INDEX_BITS]};
    assign idx_b = {i_red_b[CHAN_W-1 -: CHANNEL_INDEX_BITS],
                    i_green_b[CHAN_W-1 -: CHANNEL_INDEX_BITS],
                    i_blue_b[CHAN_W-1 -: CHANNEL_INDEX_BITS]};
    assign idx_w = IDX_W'(i_entry_index);

    // Two copies of the color table, written together
    lcdre_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_table_a (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (idx_w),
        .i_wdata (i_entry_code),
        .i_re    (pix_re),
        .i_raddr (idx_a),
        .o_rdata (code_a)
    );

    lcdre_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_table_b (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (idx_w),
        .i_wdata (i_entry_code),
        .i_re    (pix_re),
        .i_raddr (idx_b),
        .o_rdata (code_b)
    );

    // Configuration registers, held as clamped limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_lim  <= WLIM_W'(clamp_dim(CFG_W'(640), 32'(MAX_COLUMNS)));
            r_height_lim <= HLIM_W'(clamp_dim(CFG_W'(480), 32'(MAX_ROWS)));
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_width_lim <= WLIM_W'(clamp_dim(i_cfg_data, 32'(MAX_COLUMNS)));
                end
                CFG_FRAME_HEIGHT: begin
                    r_height_lim <= HLIM_W'(clamp_dim(i_cfg_data, 32'(MAX_ROWS)));
                end
                default: begin
                end
            endcase
        end
    end

    // Compare stage: codes arrive in the cycle after the lookup
    always_comb begin
        changed = (code_a != code_b);
        gap     = changed && r_run_open &&
                  (({1'b0, r_last_hit} + 1'b1) < {1'b0, r_col});
        open1   = r_run_open || changed;
        start1  = (changed && (!r_run_open || gap)) ? r_col : r_run_start;
        hit1    = changed ? r_col : r_last_hit;
        end_row = ((32'(r_col) + 32'd1) >= 32'(r_width_lim));
        seg_end = end_row && open1;
    end

    // Build result words
    always_comb begin
        res_gap           = '0;
        res_gap.changed   = changed;
        res_gap.segment_valid = 1'b1;
        res_gap.row       = FIELD_W'(r_row);
        res_gap.first_col = FIELD_W'(r_run_start);
        res_gap.final_col = FIELD_W'(r_last_hit);
        res_gap.last      = !seg_end;

        res_end           = '0;
        res_end.changed   = changed;
        res_end.segment_valid = 1'b1;
        res_end.row       = FIELD_W'(r_row);
        res_end.first_col = FIELD_W'(start1);
        res_end.final_col = FIELD_W'(hit1);
        res_end.last      = 1'b1;

        res_plain         = '0;
        res_plain.changed = changed;
        res_plain.last    = 1'b1;

        push = '0;
        if (r_s1_valid) begin
            if (gap && seg_end) begin
                push.num   = 2'd2;
                push.word0 = res_gap;
                push.word1 = res_end;
            end else if (gap) begin
                push.num   = 2'd1;
                push.word0 = res_gap;
            end else if (seg_end) begin
                push.num   = 2'd1;
                push.word0 = res_end;
            end else begin
                push.num   = 2'd1;
                push.word0 = res_plain;
            end
        end
    end

    // Next run and position state
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_run_open  = r_run_open;
        n_run_start = r_run_start;
        n_last_hit  = r_last_hit;
        if (r_s1_valid) begin
            n_run_start = start1;
            n_last_hit  = hit1;
            if (end_row) begin
                n_run_open = 1'b0;
                n_col      = '0;
                n_row      = ((32'(r_row) + 32'd1) >= 32'(r_height_lim)) ?
                             '0 : ROW_W'(r_row + 1'b1);
            end else begin
                n_run_open = open1;
                n_col      = COL_W'(r_col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
            r_last_hit  <= '0;
        end else begin
            r_s1_valid  <= pix_re;
            r_col       <= n_col;
            r_row       <= n_row;
            r_run_open  <= n_run_open;
            r_run_start <= n_run_start;
            r_last_hit  <= n_last_hit;
        end
    end

    // Result queue
    lcdre_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (oq_count),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (out_word)
    );

    assign o_changed       = out_word.changed;
    assign o_segment_valid = out_word.segment_valid;
    assign o_segment_row   = out_word.row;
    assign o_segment_first = out_word.first_col;
    assign o_segment_final = out_word.final_col;
    assign o_last          = out_word.last;

    // An accepted pixel reaches the compare stage next cycle
    a_pixel_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == ACT_PIXEL) |=> r_s1_valid)
        else $error("pixel lost before compare stage");

    // A table write never produces a result
    a_table_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == ACT_TABLE) |=> !r_s1_valid)
        else $error("table write entered compare stage");

    // A run closed by a gap starts no later than it ends
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && gap) |-> (r_run_start <= r_last_hit))
        else $error("run start beyond last hit");

    // The column counter stays below MAX_COLUMNS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(MAX_COLUMNS))
        else $error("column counter out of range");

endmodule

@@ rtl/lcdre_ram.sv @@
// ============================================================================
// lcdre_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module lcdre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lcdre_out_queue.sv @@
// ============================================================================
// lcdre_out_queue
// Result queue: takes zero, one or two words per cycle, releases one word
// per cycle on a valid/ready channel and reports its fill level.
// ============================================================================
module lcdre_out_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcdre_pkg::t_push           i_push,
    output logic [lcdre_pkg::OQ_CNT_W-1:0] o_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output lcdre_pkg::t_result         o_word
);
    import lcdre_pkg::*;

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wptr, n_wptr;
    logic [OQ_PTR_W-1:0] r_rptr, n_rptr;
    logic [OQ_CNT_W-1:0] r_count, n_count;
    logic                pop;
    logic [OQ_PTR_W-1:0] wptr_next;

    assign o_valid   = (r_count != '0);
    assign o_word    = r_mem[r_rptr];
    assign o_count   = r_count;
    assign pop       = o_valid && i_ready;
    assign wptr_next = OQ_PTR_W'(r_wptr + 1'b1);

    // Advance pointers and fill level
    always_comb begin
        n_wptr  = OQ_PTR_W'(r_wptr + OQ_PTR_W'(i_push.num));
        n_rptr  = pop ? OQ_PTR_W'(r_rptr + 1'b1) : r_rptr;
        n_count = OQ_CNT_W'(r_count + OQ_CNT_W'(i_push.num) - OQ_CNT_W'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wptr] <= i_push.word0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wptr_next] <= i_push.word1;
        end
    end

    // Fill level never passes the depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    // At most two words arrive per cycle
    a_push_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd3)
        else $error("illegal push count");

endmodule

@@ bench/lcdre_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdre_checker
// Watches both channels and the register port of the color-table change
// detector, keeps its own copy of the color table, counters and run state,
// and compares every output word with the predicted one in order.
// ----------------------------------------------------------------------------
module lcdre_checker
    import lcdre_pkg::*;
#(
    parameter int MAX_COLUMNS        = 4096,
    parameter int MAX_ROWS           = 4096,
    parameter int CHANNEL_INDEX_BITS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_action,
    input  logic [CHAN_W-1:0]    i_blue_a,
    input  logic [CHAN_W-1:0]    i_green_a,
    input  logic [CHAN_W-1:0]    i_red_a,
    input  logic [CHAN_W-1:0]    i_blue_b,
    input  logic [CHAN_W-1:0]    i_green_b,
    input  logic [CHAN_W-1:0]    i_red_b,
    input  logic [ENTRY_W-1:0]   i_entry_index,
    input  logic [CODE_W-1:0]    i_entry_code,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_changed,
    input  logic                 i_segment_valid,
    input  logic [FIELD_W-1:0]   i_segment_row,
    input  logic [FIELD_W-1:0]   i_segment_first,
    input  logic [FIELD_W-1:0]   i_segment_final,
    input  logic                 i_last,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int QSHIFT       = CHAN_W - CHANNEL_INDEX_BITS;
    localparam int BIN_W        = 3 * CHANNEL_INDEX_BITS;
    localparam int TABLE_DEPTH  = 1 << BIN_W;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int REPORT_LIMIT = 10;

    // Model state
    logic [CODE_W-1:0]  code_table [TABLE_DEPTH];
    logic [CFG_W-1:0]   frame_width;
    logic [CFG_W-1:0]   frame_height;
    logic [FIELD_W-1:0] column_pos;
    logic [FIELD_W-1:0] row_pos;
    logic               run_open;
    logic [FIELD_W-1:0] run_first;
    logic [FIELD_W-1:0] run_last;

    t_result            expected_words [$];
    int                 fail_total = 0;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int maxv);
        if (v == '0) return CFG_W'(1);
        if (v > maxv) return CFG_W'(maxv);
        return v;
    endfunction

    // Keep the top bits of each channel: red, green, blue
    function automatic logic [BIN_W-1:0] color_bin(input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] r);
        logic [CHANNEL_INDEX_BITS-1:0] qb;
        logic [CHANNEL_INDEX_BITS-1:0] qg;
        logic [CHANNEL_INDEX_BITS-1:0] qr;
        qb = CHANNEL_INDEX_BITS'(b >> QSHIFT);
        qg = CHANNEL_INDEX_BITS'(g >> QSHIFT);
        qr = CHANNEL_INDEX_BITS'(r >> QSHIFT);
        return {qr, qg, qb};
    endfunction

    function automatic t_result make_word(input logic chg, input logic seg,
                                          input logic [FIELD_W-1:0] row,
                                          input logic [FIELD_W-1:0] first,
                                          input logic [FIELD_W-1:0] fin);
        t_result w;
        w.changed       = chg;
        w.segment_valid = seg;
        w.row           = seg ? row : '0;
        w.first_col     = seg ? first : '0;
        w.final_col     = seg ? fin : '0;
        w.last          = 1'b0;
        return w;
    endfunction

    // Advance the run tracker by one pixel pair and queue its words
    task automatic predict_pixel(input logic [CHAN_W-1:0] ba, input logic [CHAN_W-1:0] ga,
                                 input logic [CHAN_W-1:0] ra, input logic [CHAN_W-1:0] bb,
                                 input logic [CHAN_W-1:0] gb, input logic [CHAN_W-1:0] rb);
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic             diff;
        t_result          words [2];
        int               n;
        w    = clamp_dim(frame_width, MAX_COLUMNS);
        h    = clamp_dim(frame_height, MAX_ROWS);
        n    = 0;
        diff = code_table[color_bin(ba, ga, ra)] != code_table[color_bin(bb, gb, rb)];

        if (diff) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_first = column_pos;
            end else if (run_last + 1 < column_pos) begin
                // a gap closes the open run
                words[n]  = make_word(diff, 1'b1, row_pos, run_first, run_last);
                n         = n + 1;
                run_first = column_pos;
            end
            run_last = column_pos;
        end

        if (column_pos + 1 >= w) begin
            // row ends here: flush any open run and wrap the column
            if (run_open) begin
                words[n] = make_word(diff, 1'b1, row_pos, run_first, run_last);
                n        = n + 1;
            end
            run_open   = 1'b0;
            column_pos = '0;
            row_pos    = (row_pos + 1 >= h) ? '0 : row_pos + 1'b1;
        end else begin
            column_pos = column_pos + 1'b1;
        end

        if (n == 0) begin
            words[0] = make_word(diff, 1'b0, '0, '0, '0);
            n        = 1;
        end
        words[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_words.push_back(words[k]);
    endtask

    task automatic report_word(input string tag, input t_result w);
        $display("  %s: changed=%0d seg=%0d row=%0d first=%0d final=%0d last=%0d",
                 tag, w.changed, w.segment_valid, w.row, w.first_col, w.final_col, w.last);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            frame_width  = CFG_W'(RESET_WIDTH);
            frame_height = CFG_W'(RESET_HEIGHT);
            column_pos   = '0;
            row_pos      = '0;
            run_open     = 1'b0;
            run_first    = '0;
            run_last     = '0;
            o_pending    <= 0;
        end else begin
            // Check the output word first: it belongs to an older pixel
            if (i_out_valid && i_out_ready) begin
                got.changed       = i_changed;
                got.segment_valid = i_segment_valid;
                got.row           = i_segment_row;
                got.first_col     = i_segment_first;
                got.final_col     = i_segment_final;
                got.last          = i_last;
                if (expected_words.size() == 0) begin
                    if (fail_total < REPORT_LIMIT) begin
                        $display("checker: output word with nothing expected at %0t", $realtime);
                        report_word("got     ", got);
                    end
                    fail_total = fail_total + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got.changed !== want.changed ||
                        got.segment_valid !== want.segment_valid ||
                        got.row !== want.row ||
                        got.first_col !== want.first_col ||
                        got.final_col !== want.final_col ||
                        got.last !== want.last) begin
                        if (fail_total < REPORT_LIMIT) begin
                            $display("checker: output word mismatch at %0t", $realtime);
                            report_word("expected", want);
                            report_word("got     ", got);
                        end
                        fail_total = fail_total + 1;
                    end
                end
            end

            // Track register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  frame_width  = i_cfg_data;
                    CFG_FRAME_HEIGHT: frame_height = i_cfg_data;
                    default: ;
                endcase
            end

            // Accepted input word: table write or pixel pair
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_TABLE) begin
                    code_table[i_entry_index[BIN_W-1:0]] = i_entry_code;
                end else begin
                    predict_pixel(i_blue_a, i_green_a, i_red_a, i_blue_b, i_green_b, i_red_b);
                end
            end
            o_pending <= expected_words.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the color-table change detector: loads the full color table, runs
// directed pixel patterns, the start of the widest row and of the deepest
// frame, then random phases under changing frame sizes with random gaps on
// both channels. The checker beside the block predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import lcdre_pkg::*;

    localparam int               LIMIT_CYCLES  = 2_000_000;
    localparam int               DRAIN_SLACK   = 6;
    localparam int               RANDOM_PHASES = 8;
    localparam int               PHASE_WORDS   = 60;
    localparam int               EDGE_WORDS    = 80;
    localparam int               MAX_DIM       = 4096;
    localparam int               TABLE_DEPTH   = 512;
    localparam logic [1:0]       CFG_SPARE_LO  = 2'd2;
    localparam logic [1:0]       CFG_SPARE_HI  = 2'd3;
    localparam logic [CHAN_W-1:0] LOW_BITS     = 8'h1F;
    localparam logic [ENTRY_W-1:0] BLACK_ENTRY = '0;
    localparam logic [ENTRY_W-1:0] WHITE_ENTRY = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 action = ACT_PIXEL;
    logic [CHAN_W-1:0]    blue_a = '0;
    logic [CHAN_W-1:0]    green_a = '0;
    logic [CHAN_W-1:0]    red_a = '0;
    logic [CHAN_W-1:0]    blue_b = '0;
    logic [CHAN_W-1:0]    green_b = '0;
    logic [CHAN_W-1:0]    red_b = '0;
    logic [ENTRY_W-1:0]   entry_index = '0;
    logic [CODE_W-1:0]    entry_code = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 changed;
    logic                 segment_valid;
    logic [FIELD_W-1:0]   segment_row;
    logic [FIELD_W-1:0]   segment_first;
    logic [FIELD_W-1:0]   segment_final;
    logic                 last;

    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    bit                   src_steady = 1'b0;
    bit                   sink_steady = 1'b0;
    int                   sink_hold = 0;
    int                   sink_words = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    lut_color_diff_run_extractor_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (action),
        .i_blue_a        (blue_a),
        .i_green_a       (green_a),
        .i_red_a         (red_a),
        .i_blue_b        (blue_b),
        .i_green_b       (green_b),
        .i_red_b         (red_b),
        .i_entry_index   (entry_index),
        .i_entry_code    (entry_code),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_changed       (changed),
        .o_segment_valid (segment_valid),
        .o_segment_row   (segment_row),
        .o_segment_first (segment_first),
        .o_segment_final (segment_final),
        .o_last          (last)
    );

    lcdre_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_action        (action),
        .i_blue_a        (blue_a),
        .i_green_a       (green_a),
        .i_red_a         (red_a),
        .i_blue_b        (blue_b),
        .i_green_b       (green_b),
        .i_red_b         (red_b),
        .i_entry_index   (entry_index),
        .i_entry_code    (entry_code),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_changed       (changed),
        .i_segment_valid (segment_valid),
        .i_segment_row   (segment_row),
        .i_segment_first (segment_first),
        .i_segment_final (segment_final),
        .i_last          (last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver: stall a random number of cycles after each word, with steady stretches
    always @(posedge clk) begin
        int draw;
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_hold <= 0;
        end else if (out_valid && out_ready) begin
            sink_words <= sink_words + 1;
            if (sink_words % 64 == 63) sink_steady <= ($urandom_range(0, 2) == 0);
            draw = sink_steady ? 0 : $urandom_range(0, 8);
            sink_hold <= draw;
            out_ready <= (draw == 0);
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            out_ready <= (sink_hold == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(input logic act,
                             input logic [CHAN_W-1:0] ba, input logic [CHAN_W-1:0] ga,
                             input logic [CHAN_W-1:0] ra, input logic [CHAN_W-1:0] bb,
                             input logic [CHAN_W-1:0] gb, input logic [CHAN_W-1:0] rb,
                             input logic [ENTRY_W-1:0] idx, input logic [CODE_W-1:0] code);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        blue_a      <= ba;
        green_a     <= ga;
        red_a       <= ra;
        blue_b      <= bb;
        green_b     <= gb;
        red_b       <= rb;
        entry_index <= idx;
        entry_code  <= code;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_table(input logic [ENTRY_W-1:0] idx, input logic [CODE_W-1:0] code);
        send_word(ACT_TABLE, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                  CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), idx, code);
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] ba, input logic [CHAN_W-1:0] ga,
                              input logic [CHAN_W-1:0] ra, input logic [CHAN_W-1:0] bb,
                              input logic [CHAN_W-1:0] gb, input logic [CHAN_W-1:0] rb);
        send_word(ACT_PIXEL, ba, ga, ra, bb, gb, rb, ENTRY_W'($urandom), CODE_W'($urandom));
    endtask

    // Same quantized bin, random low bits
    function automatic logic [CHAN_W-1:0] same_bin(input logic [CHAN_W-1:0] c);
        logic [CHAN_W-1:0] noise;
        noise = CHAN_W'($urandom);
        return (c & ~LOW_BITS) | (noise & LOW_BITS);
    endfunction

    // Black and white pixels map to the entries holding the extreme codes
    function automatic logic [CHAN_W-1:0] mono(input bit white);
        return same_bin(white ? ~LOW_BITS : '0);
    endfunction

    task automatic send_mono(input bit want_change);
        bit a_white;
        bit b_white;
        a_white = 1'($urandom_range(0, 1));
        b_white = a_white ^ want_change;
        send_pixel(mono(a_white), mono(a_white), mono(a_white),
                   mono(b_white), mono(b_white), mono(b_white));
    endtask

    task automatic send_random_pixel(input bit want_change);
        logic [CHAN_W-1:0] ba, ga, ra;
        ba = CHAN_W'($urandom);
        ga = CHAN_W'($urandom);
        ra = CHAN_W'($urandom);
        if (want_change) begin
            send_pixel(ba, ga, ra, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
        end else begin
            send_pixel(ba, ga, ra, same_bin(ba), same_bin(ga), same_bin(ra));
        end
    endtask

    // Codes cluster on a few values so compares land both ways
    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 9) == 0) return CODE_W'($urandom);
        return CODE_W'($urandom_range(0, 3));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic send_row4(input logic [3:0] pattern);
        for (int i = 3; i >= 0; i--) send_mono(pattern[i]);
    endtask

    initial begin
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        bit               run_on;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every table entry before any compare
        src_steady = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++) send_table(ENTRY_W'(i), pick_code());
        src_steady = 1'b0;

        // Directed: extreme entries, extreme pixels, a gap closing a run
        send_table(BLACK_ENTRY, 8'h00);
        send_table(WHITE_ENTRY, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_pixel(8'h1F, 8'h1F, 8'h1F, 8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h00, 8'hE0, 8'hE0, 8'hE0);
        drain();

        // Shrink the row below the current column: next pixel ends the row
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
        send_mono(1'b1);
        // Gap plus row end on a new run, run flushed by row end, full and empty rows
        send_row4(4'b1001);
        send_row4(4'b0110);
        send_row4(4'b1111);
        send_row4(4'b0000);
        drain();

        // Realign to column zero, then the start of a row at the widest clamped size
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        send_mono(1'b0);
        drain();
        write_reg(CFG_FRAME_WIDTH, '1);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        src_steady = ($urandom_range(0, 1) == 0);
        run_on = 1'b0;
        for (int k = 0; k < EDGE_WORDS; k++) begin
            if ($urandom_range(0, 3) == 0) run_on = !run_on;
            send_mono(run_on || k >= EDGE_WORDS - 2);
        end
        drain();

        // One pixel per row into the deepest frame
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(MAX_DIM));
        src_steady = ($urandom_range(0, 1) == 0);
        for (int k = 0; k < EDGE_WORDS; k++) send_mono($urandom_range(0, 2) != 0);
        drain();

        // Random phases: runs with random content, some table rewrites and noise
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0:       w = '0;
                1:       w = CFG_W'($urandom_range(MAX_DIM + 1, 8191));
                2:       w = CFG_W'($urandom_range(21, 700));
                default: w = CFG_W'($urandom_range(1, 20));
            endcase
            case ($urandom_range(0, 7))
                0:       h = '1;
                1:       h = '0;
                default: h = CFG_W'($urandom_range(1, 6));
            endcase
            write_reg(CFG_FRAME_WIDTH, w);
            write_reg(CFG_FRAME_HEIGHT, h);
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_LO, CFG_W'($urandom));
            src_steady = ($urandom_range(0, 3) == 0);
            run_on = 1'b0;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == RANDOM_PHASES / 2 && k == PHASE_WORDS / 2) drain();
                if ($urandom_range(0, 9) == 0) begin
                    send_table(ENTRY_W'($urandom), pick_code());
                end else begin
                    if ($urandom_range(0, 3) == 0) run_on = !run_on;
                    if ($urandom_range(0, 19) == 0) begin
                        send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                                   CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
                    end else begin
                        send_random_pixel(run_on);
                    end
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
